[hdl/i2cbd_pkg.sv]
// Shared types and constants for the I2C baud divider search.
// Used by hdl/i2c_baud_divider_search.sv and the testbench; depends on nothing else.
package i2cbd_pkg;

  localparam int RateW  = 20;
  localparam int ClockW = 28;
  localparam int DivW   = 8;
  localparam int ModeW  = 2;
  localparam int Modes  = 4;

  // Largest combined shift: predivider 32 times the factor two of the half step.
  localparam int ShiftMax = 6;
  // Widest scaled clock (mode 3 shifts by three) and the denominator width.
  localparam int NumW   = ClockW - ShiftMax + Modes - 1;
  localparam int DenW   = 9;

  localparam logic [ClockW-1:0] ClockReset   = 28'd69206016;
  localparam logic [ClockW-1:0] DividerMax   = 28'd255;
  localparam logic [ClockW-1:0] DividerBase  = 28'd3;

  typedef enum logic {
    REG_CLOCK_HZ = 1'b0,
    REG_FILTER   = 1'b1
  } reg_index_t;

endpackage

[hdl/i2c_baud_divider_search.sv]
// I2C baud divider search: top level, fully pipelined.
// Depends on hdl/i2cbd_pkg.sv.
//
// Takes one requested bus rate per cycle and returns the best prescaler mode and
// eight-bit divider for it, one result per request. The pipeline is 55 register
// stages deep, the first loaded at the accepting edge. A request may enter
// every cycle while the result side does not stall. The depth is set by the
// one-bit-per-stage dividers: 28 stages for clock_hz / rate, one stage that
// forms the four half values, then 25 stages for the four achieved-rate
// divisions run side by side, then one output stage that picks the winner.
// The whole pipeline advances together, so a stall on the result side holds
// every stage in place and stalls the input.
// Configuration writes are taken at any time and must only be made while no
// request is in flight.
module i2c_baud_divider_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] requested_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  mode_select,
  output logic [7:0]  divider_value,
  output logic [19:0] achieved_rate,
  output logic [19:0] rate_error,
  output logic        found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int RW = i2cbd_pkg::RateW;
  localparam int CW = i2cbd_pkg::ClockW;
  localparam int NW = i2cbd_pkg::NumW;
  localparam int DW = i2cbd_pkg::DenW;
  localparam int NM = i2cbd_pkg::Modes;

  logic [CW-1:0] clock_hz;
  logic          digital_filter;
  logic          en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz       <= i2cbd_pkg::ClockReset;
      digital_filter <= 1'b0;
    end else if (cfg_valid) begin
      unique case (i2cbd_pkg::reg_index_t'(cfg_index))
        i2cbd_pkg::REG_CLOCK_HZ: clock_hz       <= cfg_data[CW-1:0];
        i2cbd_pkg::REG_FILTER:   digital_filter <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // First divider: quotient of clock_hz by the rate, one bit per stage.
  logic          d1_v    [CW+1];
  logic [RW-1:0] d1_rate [CW+1];
  logic [RW-1:0] d1_rem  [CW+1];
  logic [CW-1:0] d1_quo  [CW+1];

  assign d1_v[0]    = in_valid;
  assign d1_rate[0] = requested_rate;
  assign d1_rem[0]  = '0;
  assign d1_quo[0]  = '0;

  for (genvar s = 0; s < CW; s++) begin : g_d1
    logic [RW:0] trial;
    logic        ge;
    assign trial = {d1_rem[s], clock_hz[CW-1-s]};
    assign ge    = trial >= {1'b0, d1_rate[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[s+1] <= 1'b0;
      end else if (en) begin
        d1_v[s+1] <= d1_v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1_rate[s+1] <= d1_rate[s];
        d1_rem[s+1]  <= ge ? RW'(trial - {1'b0, d1_rate[s]}) : trial[RW-1:0];
        d1_quo[s+1]  <= {d1_quo[s][CW-2:0], ge};
      end
    end
  end

  // Per-mode lanes. The half value of mode m is the quotient shifted right by
  // 6 - m, and the achieved rate is (clock_hz >> (6 - m)) divided by that half.
  localparam int LS = NW;
  logic          l2_v    [LS+1];
  logic [RW-1:0] l2_rate [LS+1];
  logic          l2_ok   [NM][LS+1];
  logic [7:0]    l2_div  [NM][LS+1];
  logic [DW-1:0] l2_den  [NM][LS+1];
  logic [DW-1:0] l2_rem  [NM][LS+1];
  logic [NW-1:0] l2_quo  [NM][LS+1];

  logic [CW-1:0] offset;
  assign offset = i2cbd_pkg::DividerBase + CW'({digital_filter, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_v[0] <= 1'b0;
    end else if (en) begin
      l2_v[0] <= d1_v[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_rate[0] <= d1_rate[CW];
    end
  end

  for (genvar m = 0; m < NM; m++) begin : g_lane
    logic [CW-1:0] half;
    logic [CW-1:0] scaled;
    assign half   = d1_quo[CW] >> (i2cbd_pkg::ShiftMax - m);
    assign scaled = clock_hz >> (i2cbd_pkg::ShiftMax - m);

    always_ff @(posedge clk) begin
      if (en) begin
        l2_ok[m][0]  <= (d1_rate[CW] != '0) && (half >= offset)
                        && (half <= i2cbd_pkg::DividerMax + offset);
        l2_div[m][0] <= 8'(half - offset);
        l2_den[m][0] <= half[DW-1:0];
        l2_rem[m][0] <= '0;
        l2_quo[m][0] <= '0;
      end
    end

    for (genvar s = 0; s < LS; s++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      assign trial = {l2_rem[m][s], scaled[LS-1-s]};
      assign ge    = trial >= {1'b0, l2_den[m][s]};
      always_ff @(posedge clk) begin
        if (en) begin
          l2_ok[m][s+1]  <= l2_ok[m][s];
          l2_div[m][s+1] <= l2_div[m][s];
          l2_den[m][s+1] <= l2_den[m][s];
          l2_rem[m][s+1] <= ge ? DW'(trial - {1'b0, l2_den[m][s]}) : trial[DW-1:0];
          l2_quo[m][s+1] <= {l2_quo[m][s][NW-2:0], ge};
        end
      end
    end
  end

  for (genvar s = 0; s < LS; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rst) begin
        l2_v[s+1] <= 1'b0;
      end else if (en) begin
        l2_v[s+1] <= l2_v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        l2_rate[s+1] <= l2_rate[s];
      end
    end
  end

  // Pick the lowest mode with the strictly smallest non-negative error.
  logic [1:0]    sel_mode;
  logic [7:0]    sel_div;
  logic [RW-1:0] sel_rate;
  logic [RW-1:0] sel_err;
  logic          sel_hit;

  always_comb begin
    logic [NW-1:0] rate_w;
    logic [NW-1:0] ach;
    rate_w   = NW'(l2_rate[LS]);
    sel_mode = '0;
    sel_div  = '0;
    sel_rate = '0;
    sel_err  = l2_rate[LS];
    sel_hit  = 1'b0;
    for (int m = 0; m < NM; m++) begin
      ach = l2_quo[m][LS];
      if (l2_ok[m][LS] && (ach <= rate_w)
          && (RW'(rate_w - ach) < sel_err)) begin
        sel_err  = RW'(rate_w - ach);
        sel_mode = 2'(m);
        sel_div  = l2_div[m][LS];
        sel_rate = ach[RW-1:0];
        sel_hit  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= l2_v[LS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_select   <= sel_mode;
      divider_value <= sel_div;
      achieved_rate <= sel_rate;
      rate_error    <= sel_err;
      found         <= sel_hit;
    end
  end

  a_no_hit_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> mode_select == 2'd0 && divider_value == 8'd0
                            && achieved_rate == 20'd0)
    else $error("result without a candidate is not the empty result");

  a_hit_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> achieved_rate != 20'd0)
    else $error("chosen candidate has a zero achieved rate");

  a_stall_holds_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rate_error) && $stable(found))
    else $error("stalled result changed");

endmodule

[tb/i2c_baud_divider_search_checker.sv]
// Checker for the I2C baud divider search: predicts each result from the
// accepted request beats and compares it with the output beats.
// Depends on hdl/i2cbd_pkg.sv.
`timescale 1ns / 100ps
module i2c_baud_divider_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [19:0] requested_rate,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  mode_select,
  input  logic [7:0]  divider_value,
  input  logic [19:0] achieved_rate,
  input  logic [19:0] rate_error,
  input  logic        found,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  divider;
    logic [19:0] achieved;
    logic [19:0] err;
    logic        hit;
  } baud_choice_t;

  logic [27:0] clk_hz;
  logic        filt;
  baud_choice_t choice_q[$];

  function automatic baud_choice_t search_divider(logic [19:0] rate);
    baud_choice_t c;
    longint unsigned offset, prediv, half, dv, ach, best;
    c = '0;
    offset = filt ? 64'd5 : 64'd3;
    best = 64'(rate);
    c.err = rate;
    if (rate != 0) begin
      for (int m = 0; m < i2cbd_pkg::Modes; m++) begin
        prediv = 64'd32 >> m;
        half = (clk_hz / (prediv * rate)) / 2;
        if (half < offset) continue;
        dv = half - offset;
        if (dv > 255) continue;
        ach = clk_hz / (prediv * 2 * (dv + offset));
        if (ach <= rate && (rate - ach) < best) begin
          best = rate - ach;
          c.mode = 2'(m);
          c.divider = 8'(dv);
          c.achieved = 20'(ach);
          c.err = 20'(best);
          c.hit = 1'b1;
        end
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    baud_choice_t e;
    if (rst) begin
      clk_hz <= i2cbd_pkg::ClockReset;
      filt <= 1'b0;
      fail_count <= 0;
      choice_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == i2cbd_pkg::REG_CLOCK_HZ) clk_hz <= cfg_data[27:0];
        else filt <= cfg_data[0];
      end
      if (in_valid && !in_stall) choice_q.push_back(search_divider(requested_rate));
      if (out_valid && !out_stall) begin
        if (choice_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = choice_q.pop_front();
          if (e.mode !== mode_select || e.divider !== divider_value ||
              e.achieved !== achieved_rate || e.err !== rate_error || e.hit !== found) begin
            if (e.mode !== mode_select)
              $error("mode_select exp %0d got %0d", e.mode, mode_select);
            if (e.divider !== divider_value)
              $error("divider_value exp %0d got %0d", e.divider, divider_value);
            if (e.achieved !== achieved_rate)
              $error("achieved_rate exp %0d got %0d", e.achieved, achieved_rate);
            if (e.err !== rate_error)
              $error("rate_error exp %0d got %0d", e.err, rate_error);
            if (e.hit !== found)
              $error("found exp %0d got %0d", e.hit, found);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= choice_q.size();
    end
  end

endmodule

[tb/i2c_baud_divider_search_tb.sv]
// Testbench top for the I2C baud divider search: drives request and
// configuration beats and gives the verdict. Depends on the checker and package.
`timescale 1ns / 100ps
module i2c_baud_divider_search_tb;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [19:0] requested_rate;
  logic [1:0]  mode_select;
  logic [7:0]  divider_value;
  logic [19:0] achieved_rate, rate_error;
  logic        found, cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, cycle_count;
  bit          calm, hold_long;

  i2c_baud_divider_search i_dut (.*);

  i2c_baud_divider_search_checker i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver stall: random, none while calm, and a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else
        out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  // The beat stays offered after acceptance until the next call replaces it
  // or drops valid, so back-to-back beats need no gap.
  task automatic send_rate(logic [19:0] r);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    requested_rate <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_reg(i2cbd_pkg::reg_index_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly rates near what the clock can reach, sometimes anything at all.
  function automatic logic [19:0] pick_rate();
    case ($urandom_range(3))
      0: return 20'($urandom_range(20'hFFFFF));
      1: return 20'($urandom_range(2000));
      default: return 20'($urandom_range(400000, 1));
    endcase
  endfunction

  logic [27:0] clocks[6] = '{28'd69206016, 28'hFFFFFFF, 28'd1, 28'd0,
                             28'd33000000, 28'd100000000};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    requested_rate = '0;
    cfg_valid = 1'b0;
    cfg_index = i2cbd_pkg::REG_CLOCK_HZ;
    cfg_data = '0;
    calm = 1'b0;
    hold_long = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset clock: extremes, zero request, every mode.
    foreach (requested_rate[b]) send_rate(20'd1 << b);
    send_rate(20'd0);
    send_rate(20'hFFFFF);
    send_rate(20'd100000);
    send_rate(20'd400000);
    send_rate(20'd1000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(i2cbd_pkg::REG_CLOCK_HZ, ph < 6 ? {4'hA, clocks[ph]} : $urandom());
      write_reg(i2cbd_pkg::REG_FILTER, {31'h0, ph[0]});
      calm = (ph == 4);
      for (int k = 0; k < 120; k++) begin
        if (ph == 2 && k == 10) hold_long = 1'b1;
        send_rate(pick_rate());
      end
      drain();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
